FILE: rtl/keyframe_linear_interpolator_core_defines.svh
// Assertion macros used by the keyframe interpolator controller.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Plain invariant that must hold even during reset.
`define KLI_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: rtl/kli_pkg.sv
// Package with shared constants, types and command codes of the interpolator.
package kli_pkg;
  localparam int unsigned MaxKeys     = 16;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned KeyIdxW     = $clog2(MaxKeys);
  localparam int unsigned ChanIdxW    = $clog2(MaxChannels);
  localparam int unsigned ValAddrW    = KeyIdxW + ChanIdxW;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 5;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgLoopEnable   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyCount     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd2;

  typedef struct packed {
    logic                command;
    logic [1:0]          channel_sel;
    logic [3:0]          key_index;
    logic [TimeW-1:0]    key_time;
    logic signed [ValueW-1:0] key_value;
    logic [TimeW-1:0]    query_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               out_channel;
    logic signed [ValueW-1:0] out_value;
    logic                     last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StModStart, StModWait, StLastRd, StSearchRd, StSearchCmp,
    StValRd, StValLatch, StDivStart, StDivWait, StEmit
  } ctrl_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic                load_query;
    logic                do_write;
    logic                time_rd;
    logic [KeyIdxW-1:0]  time_addr;
    logic                mod_start;
    logic                mod_take;
    logic                cmp_take;
    logic                val_rd;
    logic [ValAddrW-1:0] val_addr;
    logic                val_take_a;
    logic                div_start;
    logic                emit_load;
    logic                emit_held;
    logic [ChanIdxW-1:0] emit_ch;
    logic                emit_last;
    logic                emit_hold;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mod_done;
    logic div_done;
    logic t_lt_key;
    logic t_mod_on;
    logic equal_times;
  } dp_sts_t;
endpackage

FILE: rtl/kli_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface kli_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/kli_ram.sv
// Generic single-port RAM with registered read.
module kli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write has priority; a read returns the stored word in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end
  assign rdata_o = rdata_q;
endmodule

FILE: rtl/kli_divider.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module kli_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[31:0], quot_q[63]} - {1'b0, div_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
      end else begin
        rem_d = {rem_q[31:0], quot_q[63]};
      end
      quot_d = {quot_q[62:0], !trial[32]};
      cnt_d  = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quot_o = quot_d;
  assign rem_o  = rem_d[31:0];
endmodule

FILE: rtl/kli_datapath.sv
// Datapath: key tables, time reduction, search compare and interpolation.
module kli_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kli_pkg::in_item_t      in_i,
  input  logic                   loop_en_i,
  input  kli_pkg::dp_cmd_t       cmd_i,
  output kli_pkg::dp_sts_t       sts_o,
  output kli_pkg::out_item_t     out_o
);
  logic [kli_pkg::TimeW-1:0]  t_q, t_d, from_q, to_q;
  logic [kli_pkg::TimeW-1:0]  time_rd;
  logic signed [31:0]         val_rd, a_q;
  logic                       neg_q;
  kli_pkg::out_item_t         out_q;
  logic [63:0]                dividend, quot;
  logic [31:0]                divisor, rem;
  logic                       div_start, div_done;
  logic signed [32:0]         diff;
  logic signed [16:0]         num;
  logic signed [16:0]         den_s;
  logic [15:0]                den_mag;
  logic signed [49:0]         prod;
  logic [49:0]                mag;
  logic signed [50:0]         sum;
  logic [kli_pkg::KeyIdxW-1:0] taddr;
  logic [kli_pkg::ValAddrW-1:0] vaddr;
  logic signed [31:0]         sat;
  logic [49:0]                prod_q;
  logic [15:0]                den_q;

  assign taddr = cmd_i.do_write ? in_i.key_index[kli_pkg::KeyIdxW-1:0] : cmd_i.time_addr;
  assign vaddr = cmd_i.do_write ?
                 {in_i.channel_sel[kli_pkg::ChanIdxW-1:0],
                  in_i.key_index[kli_pkg::KeyIdxW-1:0]} : cmd_i.val_addr;

  kli_ram #(.Width(kli_pkg::TimeW), .Depth(kli_pkg::MaxKeys)) u_time_ram (
    .clk_i, .we_i(cmd_i.do_write), .re_i(cmd_i.time_rd), .addr_i(taddr),
    .wdata_i(in_i.key_time), .rdata_o(time_rd)
  );
  kli_ram #(.Width(32), .Depth(kli_pkg::MaxKeys * kli_pkg::MaxChannels)) u_val_ram (
    .clk_i, .we_i(cmd_i.do_write), .re_i(cmd_i.val_rd), .addr_i(vaddr),
    .wdata_i(in_i.key_value), .rdata_o(val_rd)
  );

  // Product (b - a) * (t - from), registered before the divider.
  assign diff = 33'(signed'({val_rd[31], val_rd})) - 33'(signed'({a_q[31], a_q}));
  assign num  = 17'(signed'({1'b0, t_q})) - 17'(signed'({1'b0, from_q}));

  // Key times need not ascend, so the segment length carries a sign too.
  assign den_s   = 17'(signed'({1'b0, to_q})) - 17'(signed'({1'b0, from_q}));
  assign den_mag = den_s[16] ? 16'(-den_s) : den_s[15:0];

  always_comb begin
    prod = 50'(diff) * 50'(num);
    mag  = prod[49] ? 50'(-prod) : 50'(prod);
  end

  // Divider is shared by the modulo reduction and the rounding quotient.
  assign div_start = cmd_i.mod_start | cmd_i.div_start;
  assign dividend  = cmd_i.mod_start ? 64'(t_q) : {13'd0, prod_q, 1'b0} + 64'(den_q);
  assign divisor   = cmd_i.mod_start ? 32'(time_rd) : {15'd0, den_q, 1'b0};

  kli_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dividend), .divisor_i(divisor),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  assign sum = neg_q ? 51'(a_q) - 51'(quot[50:0]) : 51'(a_q) + 51'(quot[50:0]);
  always_comb begin
    if (sum > 51'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -51'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    t_d = t_q;
    if (cmd_i.load_query) begin
      t_d = in_i.query_time;
    end else if (cmd_i.mod_take) begin
      t_d = rem[kli_pkg::TimeW-1:0];
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (cmd_i.cmp_take) begin
      to_q   <= time_rd;
      from_q <= to_q;
    end
    if (cmd_i.load_query) begin
      to_q <= '0;
    end
    if (cmd_i.val_take_a) begin
      a_q <= val_rd;
    end
    if (cmd_i.emit_hold) begin
      prod_q <= mag;
      neg_q  <= prod[49] ^ den_s[16];
      den_q  <= den_mag;
    end
  end

  // Output register; load picks the held value or the interpolated one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (cmd_i.emit_load) begin
      out_q.out_channel <= 2'(cmd_i.emit_ch);
      out_q.last        <= cmd_i.emit_last;
      out_q.out_value   <= cmd_i.emit_held ? a_q : sat;
    end
  end

  assign sts_o.mod_done    = div_done;
  assign sts_o.div_done    = div_done;
  assign sts_o.t_lt_key    = t_q < time_rd;
  assign sts_o.t_mod_on    = loop_en_i && (time_rd != '0);
  assign sts_o.equal_times = (to_q == from_q);
  assign out_o = out_q;
endmodule

FILE: rtl/kli_controller.sv
// Controller: sequences write, modulo, key search and per-channel interpolation.
`include "keyframe_linear_interpolator_core_defines.svh"
module kli_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic [4:0]           key_count_i,
  input  logic [2:0]           chan_count_i,
  input  kli_pkg::dp_sts_t     sts_i,
  output kli_pkg::dp_cmd_t     cmd_o
);
  kli_pkg::ctrl_state_e state_q, state_d;
  logic [4:0] k_q, k_d;
  logic [4:0] kc;
  logic [2:0] cc;
  logic [2:0] ch_q, ch_d;
  logic       found_q, found_d;
  logic       ovalid_q, ovalid_d;
  logic [kli_pkg::KeyIdxW-1:0] last_idx;
  logic [kli_pkg::KeyIdxW-1:0] row_k;
  logic       take_in;

  // Clamp register values to the supported range.
  always_comb begin
    kc = key_count_i;
    if (kc == 5'd0) kc = 5'd1;
    if (kc > 5'(kli_pkg::MaxKeys)) kc = 5'(kli_pkg::MaxKeys);
    cc = chan_count_i;
    if (cc == 3'd0) cc = 3'd1;
    if (cc > 3'(kli_pkg::MaxChannels)) cc = 3'(kli_pkg::MaxChannels);
  end
  assign last_idx = 4'(kc - 5'd1);
  assign row_k    = found_q ? k_q[3:0] : last_idx;

  assign in_ready_o  = (state_q == kli_pkg::StIdle) && !ovalid_q;
  assign take_in     = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    ch_d     = ch_q;
    found_d  = found_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.emit_ch   = 2'(ch_q);
    cmd_o.emit_last = (ch_q + 3'd1 == cc);
    case (state_q)
      kli_pkg::StIdle: begin
        if (take_in) begin
          if (in_cmd_i == kli_pkg::CmdWrite) begin
            cmd_o.do_write = 1'b1;
          end else begin
            cmd_o.load_query = 1'b1;
            cmd_o.time_rd    = 1'b1;
            cmd_o.time_addr  = last_idx;
            ch_d    = '0;
            state_d = kli_pkg::StModStart;
          end
        end
      end
      kli_pkg::StModStart: begin
        if (sts_i.t_mod_on) begin
          cmd_o.mod_start = 1'b1;
          state_d = kli_pkg::StModWait;
        end else begin
          state_d = kli_pkg::StLastRd;
        end
      end
      kli_pkg::StModWait: begin
        if (sts_i.mod_done) begin
          cmd_o.mod_take = 1'b1;
          state_d = kli_pkg::StLastRd;
        end
      end
      kli_pkg::StLastRd: begin
        // Read key 0 to seed the segment start.
        cmd_o.time_rd   = 1'b1;
        cmd_o.time_addr = '0;
        k_d     = 5'd1;
        found_d = 1'b0;
        state_d = kli_pkg::StSearchRd;
      end
      kli_pkg::StSearchRd: begin
        cmd_o.cmp_take = 1'b1;
        if (k_q >= kc) begin
          state_d = kli_pkg::StValRd;
        end else begin
          cmd_o.time_rd   = 1'b1;
          cmd_o.time_addr = k_q[3:0];
          state_d = kli_pkg::StSearchCmp;
        end
      end
      kli_pkg::StSearchCmp: begin
        if (sts_i.t_lt_key) begin
          cmd_o.cmp_take = 1'b1;
          found_d = 1'b1;
          state_d = kli_pkg::StValRd;
        end else begin
          k_d     = k_q + 5'd1;
          state_d = kli_pkg::StSearchRd;
        end
      end
      kli_pkg::StValRd: begin
        // Fetch the earlier value, or the held value when nothing was found.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.val_rd   = 1'b1;
          cmd_o.val_addr = {2'(ch_q), found_q ? 4'(k_q - 5'd1) : row_k};
          state_d = kli_pkg::StValLatch;
        end
      end
      kli_pkg::StValLatch: begin
        cmd_o.val_take_a = 1'b1;
        cmd_o.val_rd     = 1'b1;
        cmd_o.val_addr   = {2'(ch_q), row_k};
        state_d = kli_pkg::StDivStart;
      end
      kli_pkg::StDivStart: begin
        if (!found_q || sts_i.equal_times) begin
          cmd_o.emit_load = 1'b1;
          cmd_o.emit_held = 1'b1;
          state_d = kli_pkg::StEmit;
        end else begin
          cmd_o.emit_hold = 1'b1;
          state_d = kli_pkg::StDivWait;
        end
      end
      kli_pkg::StDivWait: begin
        cmd_o.div_start = 1'b1;
        state_d = kli_pkg::StEmit;
      end
      kli_pkg::StEmit: begin
        if (sts_i.div_done || !found_q || sts_i.equal_times) begin
          if (found_q && !sts_i.equal_times) begin
            cmd_o.emit_load = 1'b1;
          end
          ovalid_d = 1'b1;
          ch_d     = ch_q + 3'd1;
          if (ch_q + 3'd1 == cc) begin
            state_d = kli_pkg::StIdle;
          end else begin
            state_d = kli_pkg::StValRd;
          end
        end
      end
      default: state_d = kli_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kli_pkg::StIdle;
      k_q      <= '0;
      ch_q     <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      ch_q     <= ch_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Checks on the sequencing.
  `KLI_ASSERT(a_no_accept_busy, clk_i, rst_ni,
              (state_q != kli_pkg::StIdle) |-> !in_ready_o, "input taken while busy")
  `KLI_ASSERT(a_search_bound, clk_i, rst_ni,
              (state_q == kli_pkg::StSearchCmp) |-> (k_q < kc), "search beyond key count")
  `KLI_ASSERT(a_ch_bound, clk_i, rst_ni,
              (state_q == kli_pkg::StValRd) |-> (ch_q < cc), "channel beyond count")
endmodule

FILE: rtl/keyframe_linear_interpolator_core.sv
// Keyframe linear interpolator: top level joining controller and datapath.
// A write beat stores one key time and value. A query beat first reduces the
// query time modulo the last key time in looped mode, then walks the key times
// one key at a time, and then for each channel runs the shared iterative divide
// for the rounded quotient, or returns a held key value when no later key is
// found or the segment has zero length; the iterative divider and any output
// stalls set the query rate. Results leave through a registered output
// beat, one per channel, and a new beat is taken once the last one has left.
module keyframe_linear_interpolator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  kli_stream_if.sink                          in_if,
  kli_stream_if.source                        out_if,
  input  logic                                cfg_we_i,
  input  logic [kli_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [kli_pkg::CfgDataW-1:0]        cfg_data_i
);
  logic                loop_en_q;
  logic [4:0]          key_count_q;
  logic [2:0]          chan_count_q;
  kli_pkg::dp_cmd_t    cmd;
  kli_pkg::dp_sts_t    sts;
  kli_pkg::in_item_t   in_item;
  kli_pkg::out_item_t  out_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q    <= 1'b0;
      key_count_q  <= 5'd1;
      chan_count_q <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kli_pkg::CfgLoopEnable:   loop_en_q    <= cfg_data_i[0];
        kli_pkg::CfgKeyCount:     key_count_q  <= cfg_data_i;
        kli_pkg::CfgChannelCount: chan_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign in_item     = in_if.data;
  assign out_if.data = out_item;

  kli_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_cmd_i(in_item.command), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .key_count_i(key_count_q), .chan_count_i(chan_count_q),
    .sts_i(sts), .cmd_o(cmd)
  );

  kli_datapath u_dp (
    .clk_i, .rst_ni, .in_i(in_item), .loop_en_i(loop_en_q),
    .cmd_i(cmd), .sts_o(sts), .out_o(out_item)
  );
endmodule
